// ----- rtl/sbc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared constants for the systematic block code encoder and checker.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int MAX_MESSAGE_BITS = 8;
    localparam int MAX_CHECK_BITS   = 8;

    localparam int WORD_W    = 16;
    localparam int SYN_W     = 8;
    localparam int POS_W     = 5;
    localparam int CW_LEN_W  = 5;
    localparam int MSG_LEN_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int ROW_PITCH = 8;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODEWORD_LENGTH = 2'd0,
        REG_MESSAGE_LENGTH  = 2'd1,
        REG_PARITY_ROWS     = 2'd2
    } t_cfg_reg;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    localparam logic [CW_LEN_W-1:0]  CW_LEN_RESET  = 5'd7;
    localparam logic [MSG_LEN_W-1:0] MSG_LEN_RESET = 4'd4;

endpackage

// ----- rtl/systematic_block_code_encode_check.sv -----
// ----------------------------------------------------------------------------
// systematic_block_code_encode_check
// Systematic (n,k) GF(2) block code: encodes a message or computes the
// syndrome of a received word and locates the matching column of H.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Signals                      | Content
//  s_axis   | in  | tvalid tready tdata tuser    | word_in / operation
//  m_axis   | out | tvalid tready tdata          | codeword, syndrome, flags
//  cfg      | in  | i_cfg_we i_cfg_idx i_cfg_data| codeword/message length, P
//
//  One item per cycle while m_axis takes results; pipeline: input register,
//  parity XOR tree, column match and output register.
//  Each stage holds its item while the next one is full and stalled; a stall on m_axis
//  backs up stage by stage and drops nothing.
//  Synchronous active-low reset clears the valid bits and restores n=7, k=4,
//  P=0.
// ----------------------------------------------------------------------------
module systematic_block_code_encode_check #(
    parameter int MAX_MESSAGE_BITS = sbc_pkg::MAX_MESSAGE_BITS,
    parameter int MAX_CHECK_BITS   = sbc_pkg::MAX_CHECK_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sbc_pkg::WORD_W-1:0]        s_axis_tdata,  // [15:0] word_in
    input  logic                              s_axis_tuser,  // [0] operation
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] codeword_out, [23:16] syndrome, [24] error_seen,
    // [29:25] error_position, [30] uncorrectable, [31] zero
    output logic [sbc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sbc_pkg::*;

    localparam int KW = $clog2(MAX_MESSAGE_BITS + 1);
    localparam int RW = $clog2(MAX_CHECK_BITS + 1);

    // configuration
    logic [CW_LEN_W-1:0]       r_cw_len;
    logic [MSG_LEN_W-1:0]      r_msg_len;
    logic [MAX_CHECK_BITS-1:0] r_prow [MAX_MESSAGE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw_len  <= CW_LEN_RESET;
            r_msg_len <= MSG_LEN_RESET;
            for (int j = 0; j < MAX_MESSAGE_BITS; j++) begin
                r_prow[j] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CODEWORD_LENGTH: r_cw_len  <= i_cfg_data[CW_LEN_W-1:0];
                REG_MESSAGE_LENGTH:  r_msg_len <= i_cfg_data[MSG_LEN_W-1:0];
                REG_PARITY_ROWS: begin
                    for (int j = 0; j < MAX_MESSAGE_BITS; j++) begin
                        r_prow[j] <= i_cfg_data[ROW_PITCH*j +: MAX_CHECK_BITS];
                    end
                end
                default: ;
            endcase
        end
    end

    // clamped sizes, masked rows
    logic [MSG_LEN_W-1:0]      w_k4;
    logic signed [5:0]         w_rdiff;
    logic [MSG_LEN_W-1:0]      w_r4;
    logic [KW-1:0]             w_k;
    logic [RW-1:0]             w_r;
    logic [MAX_CHECK_BITS-1:0] w_rmask;
    logic [MAX_CHECK_BITS-1:0] w_row [MAX_MESSAGE_BITS];

    always_comb begin
        if (r_msg_len == '0) begin
            w_k4 = MSG_LEN_W'(1);
        end else if (r_msg_len > MSG_LEN_W'(MAX_MESSAGE_BITS)) begin
            w_k4 = MSG_LEN_W'(MAX_MESSAGE_BITS);
        end else begin
            w_k4 = r_msg_len;
        end
        w_rdiff = signed'({1'b0, r_cw_len}) - signed'({2'b0, w_k4});
        if (w_rdiff < 6'sd1) begin
            w_r4 = MSG_LEN_W'(1);
        end else if (w_rdiff > 6'(MAX_CHECK_BITS)) begin
            w_r4 = MSG_LEN_W'(MAX_CHECK_BITS);
        end else begin
            w_r4 = w_rdiff[MSG_LEN_W-1:0];
        end
        w_k = KW'(w_k4);
        w_r = RW'(w_r4);
        for (int c = 0; c < MAX_CHECK_BITS; c++) begin
            w_rmask[c] = (c < int'(w_r));
        end
        for (int j = 0; j < MAX_MESSAGE_BITS; j++) begin
            w_row[j] = (j < int'(w_k)) ? (r_prow[j] & w_rmask) : '0;
        end
    end

    // stage handshake
    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    assign w_en3         = !r_v3 || m_axis_tready;
    assign w_en2         = !r_v2 || w_en3;
    assign w_en1         = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;
    assign m_axis_tvalid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // stage 1: split message and received parity
    logic                        r1_op;
    logic [MAX_MESSAGE_BITS-1:0] r1_msg;
    logic [MAX_CHECK_BITS-1:0]   r1_rxp;
    logic [MAX_MESSAGE_BITS-1:0] n1_msg;
    logic [MAX_CHECK_BITS-1:0]   n1_rxp;
    logic [WORD_W-1:0]           w_upper;

    always_comb begin
        w_upper = s_axis_tdata >> w_k;
        for (int j = 0; j < MAX_MESSAGE_BITS; j++) begin
            n1_msg[j] = s_axis_tdata[j] && (j < int'(w_k));
        end
        n1_rxp = w_upper[MAX_CHECK_BITS-1:0] & w_rmask;
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && s_axis_tvalid) begin
            r1_op  <= s_axis_tuser;
            r1_msg <= n1_msg;
            r1_rxp <= n1_rxp;
        end
    end

    // stage 2: parity / syndrome
    logic                        r2_op;
    logic [MAX_MESSAGE_BITS-1:0] r2_msg;
    logic [MAX_CHECK_BITS-1:0]   r2_syn;
    logic [MAX_CHECK_BITS-1:0]   n2_syn;

    always_comb begin
        n2_syn = (r1_op == OP_CHECK) ? r1_rxp : '0;
        for (int j = 0; j < MAX_MESSAGE_BITS; j++) begin
            if (r1_msg[j]) n2_syn = n2_syn ^ w_row[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r2_op  <= r1_op;
            r2_msg <= r1_msg;
            r2_syn <= n2_syn;
        end
    end

    // stage 3: column match and result
    logic [WORD_W-1:0] n3_cw;
    logic [SYN_W-1:0]  n3_syn;
    logic              n3_seen;
    logic [POS_W-1:0]  n3_pos;
    logic              n3_unc;
    logic [POS_W-1:0]  w_row_pos;
    logic [POS_W-1:0]  w_bit_idx;

    always_comb begin
        w_row_pos = '0;
        for (int i = MAX_MESSAGE_BITS - 1; i >= 0; i--) begin
            if (w_row[i] == r2_syn) w_row_pos = POS_W'(i + 1);
        end
        w_bit_idx = '0;
        for (int c = 0; c < MAX_CHECK_BITS; c++) begin
            if (r2_syn[c]) w_bit_idx = POS_W'(c);
        end
        n3_cw   = '0;
        n3_syn  = '0;
        n3_seen = 1'b0;
        n3_pos  = '0;
        n3_unc  = 1'b0;
        if (r2_op == OP_ENCODE) begin
            n3_cw = WORD_W'(r2_msg) | (WORD_W'(r2_syn) << w_k);
        end else begin
            n3_syn  = SYN_W'(r2_syn);
            n3_seen = |r2_syn;
            if (n3_seen) begin
                if (w_row_pos != '0) begin
                    n3_pos = w_row_pos;
                end else if ($onehot(r2_syn)) begin
                    n3_pos = POS_W'(w_k) + w_bit_idx + POS_W'(1);
                end else begin
                    n3_unc = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            m_axis_tdata <= {1'b0, n3_unc, n3_pos, n3_seen, n3_syn, n3_cw};
        end
    end

endmodule

// ----- rtl/sbc_checker.sv -----
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks on the block code encoder/checker, bound to the top.
// ----------------------------------------------------------------------------
module sbc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [sbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import sbc_pkg::*;

    logic w_s_xfer;
    assign w_s_xfer = s_axis_tvalid && s_axis_tready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("not ready with empty output");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_xfer ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after three cycles");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[30] |-> m_axis_tdata[24]
            && (m_axis_tdata[29:25] == '0))
        else $error("uncorrectable flag inconsistent");

endmodule

bind systematic_block_code_encode_check sbc_checker u_sbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the systematic block code encoder and checker.
// Words are streamed in through a queue-fed driver and results are compared
// field by field against a predictor of the code. The length and parity
// registers are rewritten between drained phases. Sender gaps and receiver
// stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
    import sbc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 170;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] word;
    } t_code_item;

    typedef struct packed {
        logic [WORD_W-1:0] codeword;
        logic [SYN_W-1:0]  syndrome;
        logic              error_seen;
        logic [POS_W-1:0]  error_position;
        logic              uncorrectable;
    } t_code_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // model copy of the register file
    logic [CW_LEN_W-1:0]   cw_len   = CW_LEN_RESET;
    logic [MSG_LEN_W-1:0]  msg_len  = MSG_LEN_RESET;
    logic [CFG_DATA_W-1:0] p_matrix = '0;

    t_code_item   word_queue[$];
    t_code_result result_queue[$];

    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    logic in_taken      = 1'b0;
    int  words_in       = 0;
    int  results_out    = 0;
    int  mismatches     = 0;
    int  quiet_cycles   = 0;
    int  settings_run   = 0;

    systematic_block_code_encode_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] word_in
        .s_axis_tuser  (s_axis_tuser),   // [0] operation
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [15:0] codeword_out, [23:16] syndrome, [24] error_seen,
        // [29:25] error_position, [30] uncorrectable
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic void code_sizes(output int k, output int r);
        k = int'(msg_len);
        if (k < 1) k = 1;
        if (k > MAX_MESSAGE_BITS) k = MAX_MESSAGE_BITS;
        r = int'(cw_len) - k;
        if (r < 1) r = 1;
        if (r > MAX_CHECK_BITS) r = MAX_CHECK_BITS;
    endfunction

    function automatic t_code_result predict_code(input logic op, input logic [WORD_W-1:0] word);
        t_code_result res;
        int k, r;
        logic [SYN_W-1:0] rmask, acc, col;
        logic [WORD_W-1:0] msg;
        logic found;
        code_sizes(k, r);
        rmask = SYN_W'((1 << r) - 1);
        res   = '0;
        acc   = '0;
        found = 1'b0;
        for (int j = 0; j < k; j++) begin
            if (word[j]) acc ^= p_matrix[ROW_PITCH*j +: SYN_W] & rmask;
        end
        if (op == OP_ENCODE) begin
            msg = word & WORD_W'((1 << k) - 1);
            res.codeword = msg | ({8'd0, acc} << k);
        end else begin
            acc ^= SYN_W'(word >> k) & rmask;
            res.syndrome = acc;
            if (acc != '0) begin
                res.error_seen = 1'b1;
                for (int i = 0; i < k + r; i++) begin
                    col = (i < k) ? (p_matrix[ROW_PITCH*i +: SYN_W] & rmask)
                                  : SYN_W'(1 << (i - k));
                    if (!found && col == acc) begin
                        res.error_position = POS_W'(i + 1);
                        found = 1'b1;
                    end
                end
                res.uncorrectable = !found;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // driver: new word or gap at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= word_queue[0].op;
                s_axis_tdata  <= word_queue[0].word;
                void'(word_queue.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor: input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        t_code_result want;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            result_queue.insert(result_queue.size(), predict_code(s_axis_tuser, s_axis_tdata));
            words_in++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_out++;
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                want = result_queue.pop_front();
                if (m_axis_tdata[15:0] != want.codeword)
                    report_mismatch("codeword", 32'(m_axis_tdata[15:0]),
                                    32'(want.codeword));
                if (m_axis_tdata[23:16] != want.syndrome)
                    report_mismatch("syndrome", 32'(m_axis_tdata[23:16]),
                                    32'(want.syndrome));
                if (m_axis_tdata[24] != want.error_seen)
                    report_mismatch("error_seen", 32'(m_axis_tdata[24]),
                                    32'(want.error_seen));
                if (m_axis_tdata[29:25] != want.error_position)
                    report_mismatch("error_position", 32'(m_axis_tdata[29:25]),
                                    32'(want.error_position));
                if (m_axis_tdata[30] != want.uncorrectable)
                    report_mismatch("uncorrectable", 32'(m_axis_tdata[30]),
                                    32'(want.uncorrectable));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_word(input logic op, input logic [WORD_W-1:0] word);
        t_code_item item;
        item.op   = op;
        item.word = word;
        word_queue.insert(word_queue.size(), item);
    endtask

    task automatic drain();
        while (word_queue.size() != 0 || s_axis_tvalid || result_queue.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_CODEWORD_LENGTH: cw_len   = data[CW_LEN_W-1:0];
            REG_MESSAGE_LENGTH:  msg_len  = data[MSG_LEN_W-1:0];
            REG_PARITY_ROWS:     p_matrix = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_code(input logic [CFG_DATA_W-1:0] n, input logic [CFG_DATA_W-1:0] k,
                            input logic [CFG_DATA_W-1:0] p);
        write_reg(REG_CODEWORD_LENGTH, n);
        write_reg(REG_MESSAGE_LENGTH, k);
        write_reg(REG_PARITY_ROWS, p);
        settings_run++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin src_idle_pct = 73; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 73; end
            3:       begin src_idle_pct = 18; sink_stall_pct = 18; end
            default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    // mostly codewords with zero, one or two flipped bits; the rest encode requests and noise
    task automatic queue_random_words(input int count);
        int k, r, sel, flip;
        logic [WORD_W-1:0] word;
        t_code_result enc;
        code_sizes(k, r);
        for (int i = 0; i < count; i++) begin
            sel  = $urandom_range(99);
            word = WORD_W'($urandom);
            if (sel < 30) begin
                add_word(OP_ENCODE, word);
            end else if (sel < 85) begin
                enc  = predict_code(OP_ENCODE, word);
                word = enc.codeword;
                if (sel >= 45) begin
                    flip = $urandom_range(k + r - 1);
                    word[flip] = ~word[flip];
                end
                if (sel >= 70) begin
                    flip = $urandom_range(k + r - 1);
                    word[flip] = ~word[flip];
                end
                if ($urandom_range(3) == 0) word |= WORD_W'($urandom) << (k + r);
                add_word(OP_CHECK, word);
            end else begin
                add_word(OP_CHECK, word);
            end
        end
    endtask

    task automatic random_phase(input logic [CFG_DATA_W-1:0] n, input logic [CFG_DATA_W-1:0] k,
                                input logic [CFG_DATA_W-1:0] p, input int mode,
                                input bit mid_pause);
        drain();
        set_code(n, k, p);
        set_idling(mode);
        if (mid_pause) begin
            queue_random_words(PHASE_ITEMS / 2);
            drain();
            queue_random_words(PHASE_ITEMS - PHASE_ITEMS / 2);
        end else begin
            queue_random_words(PHASE_ITEMS);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: n=7, k=4, P all zero
        settings_run++;
        add_word(OP_ENCODE, 16'h0000);
        add_word(OP_ENCODE, 16'hFFFF);
        add_word(OP_CHECK, 16'h0000);
        add_word(OP_CHECK, 16'hFFFF);
        drain();

        // (7,4) Hamming code; a write to the spare index must change nothing
        set_code(7, 4, 64'h0000_0000_0706_0503);
        write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_word(OP_ENCODE, 16'h000F);
        add_word(OP_ENCODE, 16'h000A);
        for (int i = 0; i < 7; i++) add_word(OP_CHECK, WORD_W'(1 << i));
        add_word(OP_CHECK, 16'hFF80);
        drain();

        // (6,3): syndrome 7 matches no column
        set_code(6, 3, 64'h0000_0000_0006_0503);
        add_word(OP_CHECK, 16'h0038);
        add_word(OP_CHECK, 16'h0008);
        drain();

        // duplicate columns pick the first; unused rows and columns ignored
        set_code(6, 3, 64'hFFFF_FFFF_FFF8_0501);
        add_word(OP_CHECK, 16'h0008);
        add_word(OP_CHECK, 16'h0000);
        add_word(OP_ENCODE, 16'h0007);

        random_phase(16, 8, {$urandom, $urandom}, 0, 1'b0);
        random_phase(2, 1, {$urandom, $urandom}, 1, 1'b0);
        random_phase(0, 0, {$urandom, $urandom}, 2, 1'b0);
        random_phase(31, 15, {$urandom, $urandom}, 3, 1'b0);
        random_phase(2, 8, {$urandom, $urandom}, 0, 1'b1);
        random_phase(7, 4, 64'h0000_0000_0706_0503, 1, 1'b0);
        random_phase(31, 0, 64'hFFFF_FFFF_FFFF_FFFF, 2, 1'b0);
        for (int ph = 0; ph < 3; ph++)
            random_phase($urandom_range(31), $urandom_range(15), {$urandom, $urandom},
                         ph == 1 ? 0 : 3 - ph, 1'b0);

        while (word_queue.size() != 0 || s_axis_tvalid || result_queue.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (result_queue.size() != 0)
            report_mismatch("results never seen", result_queue.size(), 0);

        $display("covered %0d words in, %0d results out over %0d code settings",
                 words_in, results_out, settings_run);
        $display("encode/check mix with error patterns, gaps and stalls; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- systematic_block_code_encode_check.f -----
rtl/sbc_pkg.sv
rtl/systematic_block_code_encode_check.sv
rtl/sbc_checker.sv
sim/tb_top.sv
